>>> design/heater_fan_mode_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// Heater fan mode sequencer assertion macros
// Shared property shapes for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef HEATER_FAN_MODE_SEQUENCER_TOP_DEFINES_SVH
`define HEATER_FAN_MODE_SEQUENCER_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define HFM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heater fan sequencer check failed");

// The consequent holds in the cycle after the antecedent.
`define HFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heater fan sequencer check failed");

`endif

>>> design/hfm_pkg.sv
// ----------------------------------------------------------------------------
// Heater fan mode sequencer package
// Request and result types, key codes, register indexes and state layout.
// ----------------------------------------------------------------------------
package hfm_pkg;

    localparam int CountWidth = 16;
    localparam int HoldWidth  = 2;
    localparam int CfgIdxWidth = 3;

    localparam logic [2:0] KEY_STANDBY = 3'd0;
    localparam logic [2:0] KEY_LAMP    = 3'd1;
    localparam logic [2:0] KEY_HEATER  = 3'd2;
    localparam logic [2:0] KEY_FAN     = 3'd3;
    localparam logic [2:0] KEY_VENT    = 3'd4;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_KEY  = 1'b1;

    localparam logic [CfgIdxWidth-1:0] CFG_FAN_RUN     = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_VENT_RUN    = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_HEATER_RUN  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_LAMP_RUN    = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_FAN_DELAY   = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CFG_VENT_DELAY  = 3'd5;
    localparam logic [CfgIdxWidth-1:0] CFG_HEATER_DELAY = 3'd6;
    localparam logic [CfgIdxWidth-1:0] CFG_FAN_RUNON   = 3'd7;

    localparam int BIT_FAN    = 0;
    localparam int BIT_VENT   = 1;
    localparam int BIT_HEATER = 2;
    localparam int BIT_LAMP   = 3;

    localparam logic [HoldWidth-1:0] STANDBY_HOLD_TICKS = 2'd2;

    typedef logic [CountWidth-1:0] count_t;

    typedef struct packed {
        logic       mode;
        logic [2:0] key_code;
    } hfm_in_t;

    typedef struct packed {
        logic fan_relay;
        logic vent_relay;
        logic heater_relay;
        logic lamp_relay;
        logic fan_led;
        logic vent_led;
        logic heater_led;
        logic lamp_led;
        logic standby_led;
        logic beep;
    } hfm_out_t;

    typedef struct packed {
        count_t fan_run_ticks;
        count_t vent_run_ticks;
        count_t heater_run_ticks;
        count_t lamp_run_ticks;
        count_t fan_start_delay;
        count_t vent_start_delay;
        count_t heater_start_delay;
        count_t fan_runon_ticks;
    } hfm_cfg_t;

    typedef struct packed {
        count_t                fan_left;
        count_t                vent_left;
        count_t                heater_left;
        count_t                lamp_left;
        count_t                fan_wait;
        count_t                vent_wait;
        count_t                heater_wait;
        count_t                runon_left;
        logic [HoldWidth-1:0]  standby_hold;
        logic [3:0]            relay_bits;
        logic [3:0]            last_running;
    } hfm_state_t;

endpackage

>>> design/heater_fan_mode_sequencer_top.sv
// ----------------------------------------------------------------------------
// Heater fan mode sequencer
// Five-key controller for fan, vent, heater and lamp relays with run timers,
// start delays, heater fan run-on and a standby indicator hold.
// ----------------------------------------------------------------------------
//  channel   direction   signals
//  in        request     in_valid, in_ready, in_data (mode, key_code)
//  out       result      out_valid, out_ready, out_data (relays, LEDs, beep)
//  cfg       write       cfg_valid, cfg_ready, cfg_index, cfg_data
//
//  A request is registered, then processed into the result register.
//  One request per cycle is taken while the result is not stalled.
//  A stalled result holds the processing stage; the stage then holds the input.
//  Reset restores the register defaults and clears all timers and relays.
`include "heater_fan_mode_sequencer_top_defines.svh"

module heater_fan_mode_sequencer_top
    import hfm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  hfm_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hfm_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [CountWidth-1:0]  cfg_data
);

    hfm_cfg_t   cfg_reg;
    hfm_state_t state_reg;
    hfm_state_t state_next;
    hfm_in_t    stage_data_reg;
    logic       stage_valid_reg;
    hfm_out_t   out_data_reg;
    hfm_out_t   out_data_next;
    logic       out_valid_reg;
    logic       advance;
    logic       process;

    assign advance   = !out_valid_reg || out_ready;
    assign process   = stage_valid_reg && advance;
    assign in_ready  = !stage_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fan_run_ticks      <= 16'd900;
            cfg_reg.vent_run_ticks     <= 16'd900;
            cfg_reg.heater_run_ticks   <= 16'd900;
            cfg_reg.lamp_run_ticks     <= 16'd900;
            cfg_reg.fan_start_delay    <= 16'd2;
            cfg_reg.vent_start_delay   <= 16'd2;
            cfg_reg.heater_start_delay <= 16'd1;
            cfg_reg.fan_runon_ticks    <= 16'd30;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FAN_RUN:      cfg_reg.fan_run_ticks      <= cfg_data;
                CFG_VENT_RUN:     cfg_reg.vent_run_ticks     <= cfg_data;
                CFG_HEATER_RUN:   cfg_reg.heater_run_ticks   <= cfg_data;
                CFG_LAMP_RUN:     cfg_reg.lamp_run_ticks     <= cfg_data;
                CFG_FAN_DELAY:    cfg_reg.fan_start_delay    <= cfg_data;
                CFG_VENT_DELAY:   cfg_reg.vent_start_delay   <= cfg_data;
                CFG_HEATER_DELAY: cfg_reg.heater_start_delay <= cfg_data;
                CFG_FAN_RUNON:    cfg_reg.fan_runon_ticks    <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        hfm_state_t s;
        logic [3:0] run;
        logic [3:0] rise;
        logic [3:0] fall;
        logic       standby;
        logic       beep;

        s    = state_reg;
        beep = 1'b0;

        if (stage_data_reg.mode == MODE_TICK)
        begin
            if (s.fan_left != '0)
            begin
                s.fan_left = s.fan_left - 16'd1;
            end
            if (s.vent_left != '0)
            begin
                s.vent_left = s.vent_left - 16'd1;
            end
            if (s.heater_left != '0)
            begin
                s.heater_left = s.heater_left - 16'd1;
                if (s.heater_left == '0)
                begin
                    s.runon_left = cfg_reg.fan_runon_ticks;
                end
            end
            if (s.lamp_left != '0)
            begin
                s.lamp_left = s.lamp_left - 16'd1;
            end
            if (s.standby_hold != '0)
            begin
                s.standby_hold = s.standby_hold - 2'd1;
            end
            if (s.fan_wait != '0)
            begin
                s.fan_wait = s.fan_wait - 16'd1;
                if (s.fan_wait == '0)
                begin
                    s.relay_bits[BIT_FAN] = 1'b1;
                end
            end
            if (s.vent_wait != '0)
            begin
                s.vent_wait = s.vent_wait - 16'd1;
                if (s.vent_wait == '0)
                begin
                    s.relay_bits[BIT_VENT] = 1'b1;
                end
            end
            if (s.heater_wait != '0)
            begin
                s.heater_wait = s.heater_wait - 16'd1;
                if (s.heater_wait == '0)
                begin
                    s.relay_bits[BIT_HEATER] = 1'b1;
                end
            end
            if (s.runon_left != '0)
            begin
                s.runon_left = s.runon_left - 16'd1;
                if (s.runon_left == '0)
                begin
                    s.relay_bits[BIT_FAN] = 1'b0;
                end
            end
        end
        else
        begin
            beep = (stage_data_reg.key_code <= KEY_VENT);
            unique case (stage_data_reg.key_code)
                KEY_STANDBY:
                begin
                    s.fan_left  = '0;
                    s.fan_wait  = '0;
                    s.vent_left = '0;
                    s.vent_wait = '0;
                    if (s.heater_left != '0)
                    begin
                        if (s.heater_wait != '0)
                        begin
                            s.heater_wait = '0;
                            s.runon_left  = 16'd1;
                        end
                        else
                        begin
                            s.runon_left = cfg_reg.fan_runon_ticks;
                        end
                    end
                    s.heater_left  = '0;
                    s.lamp_left    = '0;
                    s.standby_hold = STANDBY_HOLD_TICKS;
                end
                KEY_LAMP:
                begin
                    if (s.lamp_left != '0)
                    begin
                        s.lamp_left = '0;
                    end
                    else
                    begin
                        s.standby_hold = '0;
                        s.lamp_left    = cfg_reg.lamp_run_ticks;
                    end
                end
                KEY_HEATER:
                begin
                    if (s.heater_left != '0)
                    begin
                        if (s.heater_wait != '0)
                        begin
                            s.heater_wait = '0;
                            s.runon_left  = 16'd1;
                        end
                        else
                        begin
                            s.runon_left = cfg_reg.fan_runon_ticks;
                        end
                        s.heater_left = '0;
                    end
                    else
                    begin
                        s.standby_hold = '0;
                        s.heater_left  = cfg_reg.heater_run_ticks;
                        if (s.fan_left == '0)
                        begin
                            s.heater_wait = cfg_reg.heater_start_delay;
                        end
                        s.fan_left  = '0;
                        s.fan_wait  = '0;
                        s.vent_left = '0;
                        s.vent_wait = '0;
                    end
                end
                KEY_FAN:
                begin
                    if (s.fan_left != '0)
                    begin
                        s.fan_left = '0;
                        s.fan_wait = '0;
                    end
                    else
                    begin
                        s.standby_hold = '0;
                        s.fan_left     = cfg_reg.fan_run_ticks;
                        s.heater_wait  = '0;
                        s.runon_left   = '0;
                        s.heater_left  = '0;
                        if (s.vent_left != '0)
                        begin
                            s.vent_left = '0;
                            s.vent_wait = '0;
                            s.fan_wait  = cfg_reg.fan_start_delay;
                        end
                    end
                end
                KEY_VENT:
                begin
                    if (s.vent_left != '0)
                    begin
                        s.vent_left = '0;
                        s.vent_wait = '0;
                    end
                    else
                    begin
                        s.standby_hold = '0;
                        s.vent_left    = cfg_reg.vent_run_ticks;
                        if (s.fan_left != '0)
                        begin
                            s.fan_left  = '0;
                            s.fan_wait  = '0;
                            s.vent_wait = cfg_reg.vent_start_delay;
                        end
                        if (s.heater_left != '0)
                        begin
                            s.heater_wait = '0;
                            s.runon_left  = 16'd1;
                            s.heater_left = '0;
                            s.vent_wait   = cfg_reg.vent_start_delay;
                        end
                    end
                end
                default:
                begin
                    s = s;
                end
            endcase
        end

        run[BIT_FAN]    = (s.fan_left != '0);
        run[BIT_VENT]   = (s.vent_left != '0);
        run[BIT_HEATER] = (s.heater_left != '0);
        run[BIT_LAMP]   = (s.lamp_left != '0);

        standby = (run == 4'd0) || (s.standby_hold != '0);
        rise    = run & ~s.last_running;
        fall    = s.last_running & ~run;

        if (rise[BIT_HEATER])
        begin
            s.relay_bits[BIT_FAN] = 1'b1;
            if (s.heater_wait == '0)
            begin
                s.relay_bits[BIT_HEATER] = 1'b1;
            end
        end
        else if (fall[BIT_HEATER])
        begin
            s.relay_bits[BIT_HEATER] = 1'b0;
        end

        if (rise[BIT_VENT])
        begin
            if (s.vent_wait == '0)
            begin
                s.relay_bits[BIT_VENT] = 1'b1;
            end
        end
        else if (fall[BIT_VENT])
        begin
            s.relay_bits[BIT_VENT] = 1'b0;
        end

        if (rise[BIT_FAN])
        begin
            if (s.fan_wait == '0)
            begin
                s.relay_bits[BIT_FAN] = 1'b1;
            end
        end
        else if (fall[BIT_FAN])
        begin
            if (s.heater_left == '0)
            begin
                s.relay_bits[BIT_FAN] = 1'b0;
            end
        end

        if (rise[BIT_LAMP])
        begin
            s.relay_bits[BIT_LAMP] = 1'b1;
        end
        else if (fall[BIT_LAMP])
        begin
            s.relay_bits[BIT_LAMP] = 1'b0;
        end

        if (rise != 4'd0)
        begin
            standby = 1'b0;
        end
        s.last_running = run;

        state_next = s;

        out_data_next.fan_relay    = s.relay_bits[BIT_FAN];
        out_data_next.vent_relay   = s.relay_bits[BIT_VENT];
        out_data_next.heater_relay = s.relay_bits[BIT_HEATER];
        out_data_next.lamp_relay   = s.relay_bits[BIT_LAMP];
        out_data_next.fan_led      = run[BIT_FAN];
        out_data_next.vent_led     = run[BIT_VENT];
        out_data_next.heater_led   = run[BIT_HEATER];
        out_data_next.lamp_led     = run[BIT_LAMP];
        out_data_next.standby_led  = standby;
        out_data_next.beep         = beep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '{last_running: 4'hF, default: '0};
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (process)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_data_reg <= in_data;
        end
        if (process)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `HFM_ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid_reg && !advance, stage_valid_reg)
    `HFM_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid_reg, in_ready)
    `HFM_ASSERT_NEXT(a_result_follows, clk, rst_n, process, out_valid_reg)
    `HFM_ASSERT_NEXT(a_fan_led_state, clk, rst_n, process,
        out_data_reg.fan_led == (state_reg.fan_left != '0))

endmodule

>>> sim/heater_fan_mode_sequencer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heater fan mode sequencer testbench
// Drives ticks and key presses with random gaps and result stalls, tracks the
// controller state in a behavioral predictor and compares every result field.
// Register settings go from defaults and zero to full scale, then to small random values.
// ----------------------------------------------------------------------------
module heater_fan_mode_sequencer_top_test;
    import hfm_pkg::*;

    localparam logic [2:0] KEY_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] KEY_LAST_CODE    = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    hfm_in_t                in_data;
    logic                   out_valid;
    logic                   out_ready;
    hfm_out_t               out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [CountWidth-1:0]  cfg_data;

    hfm_cfg_t   settings;
    count_t     fan_remaining;
    count_t     vent_remaining;
    count_t     heater_remaining;
    count_t     lamp_remaining;
    count_t     fan_delay_left;
    count_t     vent_delay_left;
    count_t     heater_delay_left;
    count_t     runon_remaining;
    logic [HoldWidth-1:0] hold_left;
    logic [3:0] relays;
    logic [3:0] prev_running;

    hfm_out_t   expected_panels[$];
    logic       back_to_back = 1'b0;
    int         failures = 0;
    int         ticks_sent = 0;
    int         keys_sent = 0;
    int         writes_done = 0;
    int         results_checked = 0;

    heater_fan_mode_sequencer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("heater_fan_mode_sequencer_top_test failed");
        $finish;
    end

    function void reset_controller_model();
        settings.fan_run_ticks      = 16'd900;
        settings.vent_run_ticks     = 16'd900;
        settings.heater_run_ticks   = 16'd900;
        settings.lamp_run_ticks     = 16'd900;
        settings.fan_start_delay    = 16'd2;
        settings.vent_start_delay   = 16'd2;
        settings.heater_start_delay = 16'd1;
        settings.fan_runon_ticks    = 16'd30;
        fan_remaining     = '0;
        vent_remaining    = '0;
        heater_remaining  = '0;
        lamp_remaining    = '0;
        fan_delay_left    = '0;
        vent_delay_left   = '0;
        heater_delay_left = '0;
        runon_remaining   = '0;
        hold_left         = '0;
        relays            = 4'b0000;
        prev_running      = 4'b1111;
    endfunction

    function void advance_tick();
        if (fan_remaining != 0) fan_remaining = fan_remaining - 1'b1;
        if (vent_remaining != 0) vent_remaining = vent_remaining - 1'b1;
        if (heater_remaining != 0)
        begin
            heater_remaining = heater_remaining - 1'b1;
            if (heater_remaining == 0) runon_remaining = settings.fan_runon_ticks;
        end
        if (lamp_remaining != 0) lamp_remaining = lamp_remaining - 1'b1;
        if (hold_left != 0) hold_left = hold_left - 1'b1;
        if (fan_delay_left != 0)
        begin
            fan_delay_left = fan_delay_left - 1'b1;
            if (fan_delay_left == 0) relays[BIT_FAN] = 1'b1;
        end
        if (vent_delay_left != 0)
        begin
            vent_delay_left = vent_delay_left - 1'b1;
            if (vent_delay_left == 0) relays[BIT_VENT] = 1'b1;
        end
        if (heater_delay_left != 0)
        begin
            heater_delay_left = heater_delay_left - 1'b1;
            if (heater_delay_left == 0) relays[BIT_HEATER] = 1'b1;
        end
        if (runon_remaining != 0)
        begin
            runon_remaining = runon_remaining - 1'b1;
            if (runon_remaining == 0) relays[BIT_FAN] = 1'b0;
        end
    endfunction

    function void stop_heater();
        if (heater_remaining != 0)
        begin
            if (heater_delay_left != 0)
            begin
                heater_delay_left = '0;
                runon_remaining   = 16'd1;
            end
            else
            begin
                runon_remaining = settings.fan_runon_ticks;
            end
        end
        heater_remaining = '0;
    endfunction

    function void press_key(logic [2:0] key);
        case (key)
            KEY_STANDBY:
            begin
                fan_remaining   = '0;
                fan_delay_left  = '0;
                vent_remaining  = '0;
                vent_delay_left = '0;
                stop_heater();
                lamp_remaining  = '0;
                hold_left       = STANDBY_HOLD_TICKS;
            end
            KEY_LAMP:
            begin
                if (lamp_remaining != 0)
                begin
                    lamp_remaining = '0;
                end
                else
                begin
                    hold_left      = '0;
                    lamp_remaining = settings.lamp_run_ticks;
                end
            end
            KEY_HEATER:
            begin
                if (heater_remaining != 0)
                begin
                    stop_heater();
                end
                else
                begin
                    hold_left        = '0;
                    heater_remaining = settings.heater_run_ticks;
                    if (fan_remaining == 0) heater_delay_left = settings.heater_start_delay;
                    fan_remaining   = '0;
                    fan_delay_left  = '0;
                    vent_remaining  = '0;
                    vent_delay_left = '0;
                end
            end
            KEY_FAN:
            begin
                if (fan_remaining != 0)
                begin
                    fan_remaining  = '0;
                    fan_delay_left = '0;
                end
                else
                begin
                    hold_left         = '0;
                    fan_remaining     = settings.fan_run_ticks;
                    heater_delay_left = '0;
                    runon_remaining   = '0;
                    heater_remaining  = '0;
                    if (vent_remaining != 0)
                    begin
                        vent_remaining  = '0;
                        vent_delay_left = '0;
                        fan_delay_left  = settings.fan_start_delay;
                    end
                end
            end
            KEY_VENT:
            begin
                if (vent_remaining != 0)
                begin
                    vent_remaining  = '0;
                    vent_delay_left = '0;
                end
                else
                begin
                    hold_left      = '0;
                    vent_remaining = settings.vent_run_ticks;
                    if (fan_remaining != 0)
                    begin
                        fan_remaining   = '0;
                        fan_delay_left  = '0;
                        vent_delay_left = settings.vent_start_delay;
                    end
                    if (heater_remaining != 0)
                    begin
                        heater_delay_left = '0;
                        runon_remaining   = 16'd1;
                        heater_remaining  = '0;
                        vent_delay_left   = settings.vent_start_delay;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function hfm_out_t predict_panel(hfm_in_t req);
        logic [3:0] running;
        logic [3:0] rising;
        logic [3:0] falling;
        logic       idle_led;
        hfm_out_t   panel;
        panel = '0;
        if (req.mode == MODE_TICK)
        begin
            advance_tick();
        end
        else
        begin
            panel.beep = (req.key_code <= KEY_VENT);
            press_key(req.key_code);
        end
        running = 4'b0000;
        running[BIT_FAN]    = (fan_remaining != 0);
        running[BIT_VENT]   = (vent_remaining != 0);
        running[BIT_HEATER] = (heater_remaining != 0);
        running[BIT_LAMP]   = (lamp_remaining != 0);
        idle_led = (running == 4'b0000) || (hold_left != 0);
        rising   = running & ~prev_running;
        falling  = prev_running & ~running;
        if (rising[BIT_HEATER])
        begin
            relays[BIT_FAN] = 1'b1;
            if (heater_delay_left == 0) relays[BIT_HEATER] = 1'b1;
        end
        else if (falling[BIT_HEATER])
        begin
            relays[BIT_HEATER] = 1'b0;
        end
        if (rising[BIT_VENT])
        begin
            if (vent_delay_left == 0) relays[BIT_VENT] = 1'b1;
        end
        else if (falling[BIT_VENT])
        begin
            relays[BIT_VENT] = 1'b0;
        end
        if (rising[BIT_FAN])
        begin
            if (fan_delay_left == 0) relays[BIT_FAN] = 1'b1;
        end
        else if (falling[BIT_FAN])
        begin
            if (heater_remaining == 0) relays[BIT_FAN] = 1'b0;
        end
        if (rising[BIT_LAMP]) relays[BIT_LAMP] = 1'b1;
        else if (falling[BIT_LAMP]) relays[BIT_LAMP] = 1'b0;
        if (rising != 4'b0000) idle_led = 1'b0;
        prev_running = running;
        panel.fan_relay    = relays[BIT_FAN];
        panel.vent_relay   = relays[BIT_VENT];
        panel.heater_relay = relays[BIT_HEATER];
        panel.lamp_relay   = relays[BIT_LAMP];
        panel.fan_led      = running[BIT_FAN];
        panel.vent_led     = running[BIT_VENT];
        panel.heater_led   = running[BIT_HEATER];
        panel.lamp_led     = running[BIT_LAMP];
        panel.standby_led  = idle_led;
        return panel;
    endfunction

    function string panel_field_name(int pos);
        case (pos)
            9: return "fan_relay";
            8: return "vent_relay";
            7: return "heater_relay";
            6: return "lamp_relay";
            5: return "fan_led";
            4: return "vent_led";
            3: return "heater_led";
            2: return "lamp_led";
            1: return "standby_led";
            default: return "beep";
        endcase
    endfunction

    function void note_failure(string msg);
        failures++;
        if (failures <= 10) $display("%s", msg);
    endfunction

    always @(posedge clk)
    begin
        hfm_out_t expected;
        string    wrong_fields;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_panels.size() == 0)
            begin
                note_failure($sformatf("unexpected result %b with no request pending",
                    out_data));
            end
            else
            begin
                expected = expected_panels.pop_front();
                wrong_fields = "";
                for (int pos = 0; pos < $bits(hfm_out_t); pos++)
                begin
                    if (out_data[pos] !== expected[pos])
                        wrong_fields = {wrong_fields, " ", panel_field_name(pos)};
                end
                if (wrong_fields != "")
                    note_failure($sformatf("result %0d mismatch:%s expected %b actual %b",
                        results_checked, wrong_fields, expected, out_data));
                results_checked++;
            end
        end
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = back_to_back ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    task send_event(input logic mode, input logic [2:0] key);
        hfm_in_t req;
        int      gap;
        req.mode     = mode;
        req.key_code = key;
        gap = back_to_back ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        do @(posedge clk); while (!in_ready);
        expected_panels.push_back(predict_panel(req));
        if (mode == MODE_TICK) ticks_sent++;
        else keys_sent++;
    endtask

    task send_tick();
        send_event(MODE_TICK, 3'($urandom_range(0, KEY_LAST_CODE)));
    endtask

    task wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_panels.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task write_register(input logic [CfgIdxWidth-1:0] index, input count_t value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_FAN_RUN:      settings.fan_run_ticks      = value;
            CFG_VENT_RUN:     settings.vent_run_ticks     = value;
            CFG_HEATER_RUN:   settings.heater_run_ticks   = value;
            CFG_LAMP_RUN:     settings.lamp_run_ticks     = value;
            CFG_FAN_DELAY:    settings.fan_start_delay    = value;
            CFG_VENT_DELAY:   settings.vent_start_delay   = value;
            CFG_HEATER_DELAY: settings.heater_start_delay = value;
            CFG_FAN_RUNON:    settings.fan_runon_ticks    = value;
            default:
            begin
            end
        endcase
        writes_done++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task write_all_registers(input hfm_cfg_t s);
        write_register(CFG_FAN_RUN, s.fan_run_ticks);
        write_register(CFG_VENT_RUN, s.vent_run_ticks);
        write_register(CFG_HEATER_RUN, s.heater_run_ticks);
        write_register(CFG_LAMP_RUN, s.lamp_run_ticks);
        write_register(CFG_FAN_DELAY, s.fan_start_delay);
        write_register(CFG_VENT_DELAY, s.vent_start_delay);
        write_register(CFG_HEATER_DELAY, s.heater_start_delay);
        write_register(CFG_FAN_RUNON, s.fan_runon_ticks);
    endtask

    function count_t random_run_length();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return count_t'($urandom_range(1, 12));
    endfunction

    function count_t random_delay(int upper);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '1;
        return count_t'($urandom_range(0, upper));
    endfunction

    function hfm_cfg_t random_settings();
        hfm_cfg_t s;
        s.fan_run_ticks      = random_run_length();
        s.vent_run_ticks     = random_run_length();
        s.heater_run_ticks   = random_run_length();
        s.lamp_run_ticks     = random_run_length();
        s.fan_start_delay    = random_delay(4);
        s.vent_start_delay   = random_delay(4);
        s.heater_start_delay = random_delay(4);
        s.fan_runon_ticks    = random_delay(8);
        return s;
    endfunction

    // Reset register values; the first event sees every function fall.
    task test_default_keys();
        send_tick();
        send_event(MODE_KEY, KEY_LAMP);
        send_event(MODE_KEY, KEY_HEATER);
        send_tick();
        send_tick();
        send_event(MODE_KEY, KEY_VENT);
        send_event(MODE_KEY, KEY_FAN);
        send_event(MODE_KEY, KEY_STANDBY);
        send_event(MODE_KEY, KEY_FIRST_UNUSED);
        send_event(MODE_KEY, KEY_LAST_CODE);
    endtask

    task test_zero_settings();
        hfm_cfg_t s;
        s = '0;
        wait_for_results();
        write_all_registers(s);
        send_event(MODE_KEY, KEY_LAMP);
        send_event(MODE_KEY, KEY_FAN);
        send_event(MODE_KEY, KEY_HEATER);
        wait_for_results();
        write_register(CFG_HEATER_RUN, 16'd1);
        send_event(MODE_KEY, KEY_HEATER);
        send_tick();
        wait_for_results();
        write_register(CFG_FAN_RUN, 16'd3);
        write_register(CFG_VENT_RUN, 16'd3);
        send_event(MODE_KEY, KEY_VENT);
        send_event(MODE_KEY, KEY_FAN);
        send_event(MODE_KEY, KEY_STANDBY);
    endtask

    task test_heater_restart_in_runon();
        wait_for_results();
        write_register(CFG_HEATER_RUN, 16'd2);
        write_register(CFG_HEATER_DELAY, 16'd1);
        write_register(CFG_FAN_RUNON, 16'd4);
        send_event(MODE_KEY, KEY_HEATER);
        send_tick();
        send_tick();
        send_event(MODE_KEY, KEY_HEATER);
        send_tick();
        send_tick();
        send_tick();
    endtask

    task test_full_scale_settings();
        hfm_cfg_t s;
        s = '1;
        wait_for_results();
        write_all_registers(s);
        send_event(MODE_KEY, KEY_LAMP);
        send_event(MODE_KEY, KEY_FAN);
        send_event(MODE_KEY, KEY_VENT);
        send_tick();
    endtask

    // The sender drains all results before each new setting is written.
    task test_random_phases();
        hfm_cfg_t s;
        int       pick;
        for (int phase = 0; phase < 15; phase++)
        begin
            wait_for_results();
            s = random_settings();
            write_all_registers(s);
            back_to_back = (phase % 5 == 4);
            repeat (60)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    send_tick();
                else if (pick < 93)
                    send_event(MODE_KEY, 3'($urandom_range(KEY_STANDBY, KEY_VENT)));
                else
                    send_event(MODE_KEY, 3'($urandom_range(KEY_FIRST_UNUSED, KEY_LAST_CODE)));
            end
        end
        back_to_back = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_controller_model();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_default_keys();
        test_zero_settings();
        test_heater_restart_in_runon();
        test_full_scale_settings();
        test_random_phases();
        wait_for_results();

        $display("Sent %0d key presses and %0d ticks across %0d register writes.",
            keys_sent, ticks_sent, writes_done);
        $display("Compared %0d results field by field, %0d failures seen.",
            results_checked, failures);
        if (failures == 0)
            $display("heater_fan_mode_sequencer_top_test passed");
        else
            $display("heater_fan_mode_sequencer_top_test failed");
        $finish;
    end

endmodule

>>> heater_fan_mode_sequencer_top.f
+incdir+design
design/hfm_pkg.sv
design/heater_fan_mode_sequencer_top.sv
sim/heater_fan_mode_sequencer_top_test.sv
